// ----- rtl/core/tptu_pkg.sv -----
// ----------------------------------------------------------------------------
// TLB page table translator package
// Shared types and constants for the controller, datapath and top level.
// ----------------------------------------------------------------------------
package tptu_pkg;

   localparam int ADDR_W         = 16;
   localparam int PAGE_W         = 8;
   localparam int OFFSET_W       = 8;
   localparam int FRAME_W        = 8;
   localparam int COUNT_W        = 32;
   localparam int FCOUNT_W       = 9;
   localparam int PAGE_ENTRIES   = 256;
   localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 9'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_EVICT,
      ST_RESP
   } tptu_state_type;

   typedef struct packed {
      logic capture;
      logic fin_hit;
      logic fin_walk;
      logic fault_sel;
      logic fault_commit;
   } tptu_cmd_type;

   typedef struct packed {
      logic tlb_hit;
      logic page_resident;
   } tptu_status_type;

endpackage

// ----- rtl/core/tlb_page_table_translator_unit.sv -----
// ----------------------------------------------------------------------------
// TLB page table translator unit
// Translates 16-bit logical addresses through a FIFO TLB and a page table.
// ----------------------------------------------------------------------------
// An address is taken when start is high and busy is low. The upper byte is
// the page number and the lower byte the offset. One result beat follows on
// the rsp_ ports, marked by rsp_strobe for exactly one cycle; it carries the
// physical address, hit and fault flags and saturating 32-bit totals.
// For a TLB hit or a resident page, the beat is shown in the response state
// that follows the lookup state; for a page fault, an eviction state lies
// between them. Busy stays high until the beat has been shown, so one
// address is in work at a time, and a new address is taken only in idle.
// The page table read is registered when the address is taken.
// The csr_ channel writes the frame count and is always ready; the user must
// write it only while busy is low; the block does not enforce this.
// Reset clears the TLB, the resident and in-use maps, the allocator and the
// counters, and loads a frame count of 256.
// The receiver cannot stall: each beat is valid for its one cycle only.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_unit #(
   parameter int TLB_ENTRIES = 16,
   parameter int MAX_FRAMES  = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tptu_pkg::ADDR_W-1:0]   req_logical_address,
   output logic                          rsp_strobe,
   output logic [tptu_pkg::ADDR_W-1:0]   rsp_physical_address,
   output logic                          rsp_tlb_hit,
   output logic                          rsp_page_fault,
   output logic [tptu_pkg::COUNT_W-1:0]  rsp_access_total,
   output logic [tptu_pkg::COUNT_W-1:0]  rsp_fault_total,
   output logic [tptu_pkg::COUNT_W-1:0]  rsp_hit_total,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tptu_pkg::FCOUNT_W-1:0] csr_frame_count
);
   import tptu_pkg::*;

   tptu_cmd_type    cmd;
   tptu_status_type status;

   assign csr_ready = 1'b1;

   tptu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .status     (status),
      .cmd        (cmd)
   );

   tptu_dp #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .MAX_FRAMES  (MAX_FRAMES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_logical_address  (req_logical_address),
      .csr_write            (csr_valid & csr_ready),
      .csr_frame_count      (csr_frame_count),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_access_total     (rsp_access_total),
      .rsp_fault_total      (rsp_fault_total),
      .rsp_hit_total        (rsp_hit_total)
   );

endmodule

// ----- rtl/core/tptu_ctrl.sv -----
// ----------------------------------------------------------------------------
// TLB page table translator controller
// Sequences lookup, page walk, fault handling and the result beat.
// ----------------------------------------------------------------------------
module tptu_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_strobe,
   input  tptu_pkg::tptu_status_type status,
   output tptu_pkg::tptu_cmd_type   cmd
);
   import tptu_pkg::*;

   tptu_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (status.tlb_hit) begin
               cmd.fin_hit = 1'b1;
               state_in    = ST_RESP;
            end else if (status.page_resident) begin
               cmd.fin_walk = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.fault_sel = 1'b1;
               state_in      = ST_EVICT;
            end
         end
         ST_EVICT: begin
            cmd.fault_commit = 1'b1;
            state_in         = ST_RESP;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/tptu_dp.sv -----
// ----------------------------------------------------------------------------
// TLB page table translator datapath
// TLB lanes, page table memories, frame allocator and saturating counters.
// ----------------------------------------------------------------------------
module tptu_dp #(
   parameter int TLB_ENTRIES = 16,
   parameter int MAX_FRAMES  = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tptu_pkg::tptu_cmd_type               cmd,
   output tptu_pkg::tptu_status_type            status,
   input  logic [tptu_pkg::ADDR_W-1:0]          req_logical_address,
   input  logic                                 csr_write,
   input  logic [tptu_pkg::FCOUNT_W-1:0]        csr_frame_count,
   output logic [tptu_pkg::ADDR_W-1:0]          rsp_physical_address,
   output logic                                 rsp_tlb_hit,
   output logic                                 rsp_page_fault,
   output logic [tptu_pkg::COUNT_W-1:0]         rsp_access_total,
   output logic [tptu_pkg::COUNT_W-1:0]         rsp_fault_total,
   output logic [tptu_pkg::COUNT_W-1:0]         rsp_hit_total
);
   import tptu_pkg::*;

   localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam logic [TW-1:0] TLB_LAST = TW'(TLB_ENTRIES - 1);
   localparam logic [FCOUNT_W-1:0] FRAMES_MAX = FCOUNT_W'(MAX_FRAMES);

   logic [FCOUNT_W-1:0] fcount_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [FRAME_W-1:0]  pt_rd_ff;
   logic [PAGE_W-1:0]   owner_rd_ff;
   logic [FRAME_W-1:0]  frame_ff;
   logic [FRAME_W-1:0]  victim_ff;
   logic [FRAME_W-1:0]  rsp_frame_ff;
   logic                hit_ff;
   logic                fault_ff;
   logic [COUNT_W-1:0]  acc_ff, flt_ff, hct_ff;

   logic [PAGE_W-1:0]   tlb_tag_ff [TLB_ENTRIES];
   logic [FRAME_W-1:0]  tlb_frm_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] tlb_val_ff;
   logic [TW-1:0]       tlb_ptr_ff;

   logic [FRAME_W-1:0]  pt_mem    [PAGE_ENTRIES];
   logic [PAGE_W-1:0]   owner_mem [MAX_FRAMES];
   logic [PAGE_ENTRIES-1:0] resident_ff;
   logic [MAX_FRAMES-1:0]   in_use_ff;

   logic                hit_c;
   logic [FRAME_W-1:0]  hit_frame_c;
   logic                evict_tlb_c;
   logic [TW-1:0]       evict_idx_c;
   logic [FCOUNT_W-1:0] nframes_c;
   logic [FRAME_W-1:0]  victim_c;
   logic [FCOUNT_W-1:0] next_c;
   logic                finish_c;
   logic                insert_c;
   logic [FRAME_W-1:0]  ins_frame_c;

   always_comb begin
      hit_c       = 1'b0;
      hit_frame_c = '0;
      evict_tlb_c = 1'b0;
      evict_idx_c = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_val_ff[i] && tlb_tag_ff[i] == page_ff) begin
            hit_c       = 1'b1;
            hit_frame_c = tlb_frm_ff[i];
         end
         if (tlb_val_ff[i] && tlb_frm_ff[i] == frame_ff) begin
            evict_tlb_c = 1'b1;
            evict_idx_c = TW'(i);
         end
      end
   end

   always_comb begin
      nframes_c = fcount_ff;
      if (fcount_ff == '0) begin
         nframes_c = FCOUNT_W'(1);
      end else if (fcount_ff > FRAMES_MAX) begin
         nframes_c = FRAMES_MAX;
      end
      victim_c = ({1'b0, victim_ff} < nframes_c) ? victim_ff : '0;
      next_c   = {1'b0, frame_ff} + FCOUNT_W'(1);
   end

   assign status.tlb_hit       = hit_c;
   assign status.page_resident = resident_ff[page_ff];

   assign finish_c    = cmd.fin_hit | cmd.fin_walk | cmd.fault_commit;
   assign insert_c    = cmd.fin_walk | cmd.fault_commit;
   assign ins_frame_c = cmd.fin_walk ? pt_rd_ff : frame_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         page_ff   <= req_logical_address[ADDR_W-1:OFFSET_W];
         offset_ff <= req_logical_address[OFFSET_W-1:0];
         pt_rd_ff  <= pt_mem[req_logical_address[ADDR_W-1:OFFSET_W]];
      end
      if (cmd.fault_sel) begin
         frame_ff    <= victim_c;
         owner_rd_ff <= owner_mem[victim_c[FW-1:0]];
      end
      if (cmd.fault_commit) begin
         pt_mem[page_ff]              <= frame_ff;
         owner_mem[frame_ff[FW-1:0]]  <= page_ff;
      end
      if (insert_c) begin
         tlb_tag_ff[tlb_ptr_ff] <= page_ff;
         tlb_frm_ff[tlb_ptr_ff] <= ins_frame_c;
      end
      if (finish_c) begin
         rsp_frame_ff <= cmd.fin_hit ? hit_frame_c : ins_frame_c;
         hit_ff       <= cmd.fin_hit;
         fault_ff     <= cmd.fault_commit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fcount_ff   <= FCOUNT_RESET;
         tlb_val_ff  <= '0;
         tlb_ptr_ff  <= '0;
         resident_ff <= '0;
         in_use_ff   <= '0;
         victim_ff   <= '0;
         acc_ff      <= '0;
         flt_ff      <= '0;
         hct_ff      <= '0;
      end else begin
         if (csr_write) begin
            fcount_ff <= csr_frame_count;
         end
         if (cmd.fault_commit) begin
            if (in_use_ff[frame_ff[FW-1:0]]) begin
               resident_ff[owner_rd_ff] <= 1'b0;
               if (evict_tlb_c) begin
                  tlb_val_ff[evict_idx_c] <= 1'b0;
               end
            end
            resident_ff[page_ff]          <= 1'b1;
            in_use_ff[frame_ff[FW-1:0]]   <= 1'b1;
            victim_ff <= (next_c == nframes_c) ? '0 : next_c[FRAME_W-1:0];
         end
         if (insert_c) begin
            tlb_val_ff[tlb_ptr_ff] <= 1'b1;
            tlb_ptr_ff <= (tlb_ptr_ff == TLB_LAST) ? '0 : tlb_ptr_ff + TW'(1);
         end
         if (finish_c) begin
            if (acc_ff != '1) begin
               acc_ff <= acc_ff + COUNT_W'(1);
            end
            if (cmd.fault_commit && flt_ff != '1) begin
               flt_ff <= flt_ff + COUNT_W'(1);
            end
            if (cmd.fin_hit && hct_ff != '1) begin
               hct_ff <= hct_ff + COUNT_W'(1);
            end
         end
      end
   end

   assign rsp_physical_address = {rsp_frame_ff, offset_ff};
   assign rsp_tlb_hit          = hit_ff;
   assign rsp_page_fault       = fault_ff;
   assign rsp_access_total     = acc_ff;
   assign rsp_fault_total      = flt_ff;
   assign rsp_hit_total        = hct_ff;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for the TLB page table translator unit
// Feeds logical addresses and frame count writes, predicts each result beat
// with a local TLB, page table and frame allocator, and checks every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import tptu_pkg::*;

   typedef enum logic [1:0] {
      JOB_ADDR,
      JOB_CSR,
      JOB_DRAIN
   } job_kind_type;

   typedef struct {
      job_kind_type kind;
      logic [ADDR_W-1:0] addr;
      logic [FCOUNT_W-1:0] fcount;
   } job_type;

   typedef struct {
      logic [ADDR_W-1:0] phys;
      logic hit;
      logic fault;
      logic [COUNT_W-1:0] acc;
      logic [COUNT_W-1:0] flt;
      logic [COUNT_W-1:0] hits;
   } xlat_type;

   localparam int TLB_N = 16;
   localparam int FRAMES_N = 256;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [ADDR_W-1:0] req_logical_address = '0;
   logic rsp_strobe;
   logic [ADDR_W-1:0] rsp_physical_address;
   logic rsp_tlb_hit;
   logic rsp_page_fault;
   logic [COUNT_W-1:0] rsp_access_total;
   logic [COUNT_W-1:0] rsp_fault_total;
   logic [COUNT_W-1:0] rsp_hit_total;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [FCOUNT_W-1:0] csr_frame_count = '0;

   tlb_page_table_translator_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_logical_address(req_logical_address),
      .rsp_strobe(rsp_strobe),
      .rsp_physical_address(rsp_physical_address),
      .rsp_tlb_hit(rsp_tlb_hit),
      .rsp_page_fault(rsp_page_fault),
      .rsp_access_total(rsp_access_total),
      .rsp_fault_total(rsp_fault_total),
      .rsp_hit_total(rsp_hit_total),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_frame_count(csr_frame_count)
   );

   job_type pending_jobs[$];
   xlat_type expected_xlats[$];
   int errors = 0;
   int addrs_sent = 0;
   int quiet_cycles = 0;
   int idle_cycles = 0;
   logic addr_taken = 1'b0;
   logic csr_taken = 1'b0;

   // Shadow copy of the translator state.
   logic [FCOUNT_W-1:0] shadow_fcount;
   logic [7:0] tlb_tag[TLB_N];
   logic [7:0] tlb_frame[TLB_N];
   logic tlb_valid[TLB_N];
   int tlb_ptr;
   logic [7:0] page_frame[PAGE_ENTRIES];
   logic page_valid[PAGE_ENTRIES];
   logic frame_used[FRAMES_N];
   int victim;
   logic [COUNT_W-1:0] acc_count, flt_count, hit_count;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic xlat_type translate(logic [ADDR_W-1:0] addr);
      xlat_type r;
      int page;
      int frame;
      int n;
      logic hit;
      logic fault;
      page = addr[15:8];
      frame = 0;
      hit = 1'b0;
      fault = 1'b0;
      for (int i = 0; i < TLB_N; i++) begin
         if (!hit && tlb_valid[i] && tlb_tag[i] == page) begin
            hit = 1'b1;
            frame = tlb_frame[i];
         end
      end
      if (!hit) begin
         if (page_valid[page]) begin
            frame = page_frame[page];
         end else begin
            n = (shadow_fcount == 0) ? 1 : (shadow_fcount > FRAMES_N) ? FRAMES_N
                  : int'(shadow_fcount);
            fault = 1'b1;
            frame = (victim < n) ? victim : 0;
            if (frame_used[frame]) begin
               for (int i = 0; i < PAGE_ENTRIES; i++) begin
                  if (page_valid[i] && page_frame[i] == frame) begin
                     page_valid[i] = 1'b0;
                     break;
                  end
               end
               for (int i = 0; i < TLB_N; i++) begin
                  if (tlb_valid[i] && tlb_frame[i] == frame) begin
                     tlb_valid[i] = 1'b0;
                     break;
                  end
               end
            end
            page_frame[page] = frame[7:0];
            page_valid[page] = 1'b1;
            frame_used[frame] = 1'b1;
            victim = (frame + 1) % n;
         end
         tlb_tag[tlb_ptr] = page[7:0];
         tlb_frame[tlb_ptr] = frame[7:0];
         tlb_valid[tlb_ptr] = 1'b1;
         tlb_ptr = (tlb_ptr + 1) % TLB_N;
      end
      acc_count = bump(acc_count);
      if (fault) flt_count = bump(flt_count);
      if (hit) hit_count = bump(hit_count);
      r.phys = {frame[7:0], addr[7:0]};
      r.hit = hit;
      r.fault = fault;
      r.acc = acc_count;
      r.flt = flt_count;
      r.hits = hit_count;
      return r;
   endfunction

   task automatic compare_field(string name, logic [COUNT_W-1:0] want,
                                logic [COUNT_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic add_addr(logic [ADDR_W-1:0] a);
      pending_jobs.push_back('{JOB_ADDR, a, '0});
   endtask

   task automatic add_csr(logic [FCOUNT_W-1:0] f);
      pending_jobs.push_back('{JOB_DRAIN, '0, '0});
      pending_jobs.push_back('{JOB_CSR, '0, f});
   endtask

   task automatic add_random_block(int count);
      int span;
      logic [7:0] page;
      span = $urandom_range(40, 3);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 75) page = 8'($urandom_range(span));
         else page = 8'($urandom);
         add_addr({page, 8'($urandom)});
      end
   endtask

   // Monitor: records accepted beats, predicts and checks results.
   always @(posedge clock) begin
      xlat_type want;
      if (!reset) begin
         addr_taken <= start && !busy;
         csr_taken <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) shadow_fcount = csr_frame_count;
         if (start && !busy) expected_xlats.push_back(translate(req_logical_address));
         if (rsp_strobe) begin
            if (expected_xlats.size() == 0) begin
               errors++;
               $display("%0t: result beat with nothing expected, actual %h", $time,
                        rsp_physical_address);
            end else begin
               want = expected_xlats.pop_front();
               compare_field("physical_address", 32'(want.phys), 32'(rsp_physical_address));
               compare_field("tlb_hit", 32'(want.hit), 32'(rsp_tlb_hit));
               compare_field("page_fault", 32'(want.fault), 32'(rsp_page_fault));
               compare_field("access_total", want.acc, rsp_access_total);
               compare_field("fault_total", want.flt, rsp_fault_total);
               compare_field("hit_total", want.hits, rsp_hit_total);
            end
         end
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Driver: presents jobs from the pending queue at the falling edge.
   always @(negedge clock) begin
      logic next_start;
      logic next_csr;
      int idle_pct;
      job_type job;
      if (!reset) begin
         next_start = start && !addr_taken;
         next_csr = csr_valid && !csr_taken;
         if (expected_xlats.size() == 0 && !busy && !next_start && !next_csr)
            quiet_cycles = quiet_cycles + 1;
         else quiet_cycles = 0;
         idle_pct = (addrs_sent < 620) ? 7 : (addrs_sent < 1240) ? 55 : 0;
         if (!next_start && !next_csr && pending_jobs.size() != 0) begin
            job = pending_jobs[0];
            if (job.kind == JOB_ADDR) begin
               if ($urandom_range(99) >= idle_pct) begin
                  void'(pending_jobs.pop_front());
                  next_start = 1'b1;
                  req_logical_address <= job.addr;
                  addrs_sent++;
               end
            end else if (quiet_cycles >= SETTLE_CYCLES) begin
               void'(pending_jobs.pop_front());
               if (job.kind == JOB_CSR) begin
                  next_csr = 1'b1;
                  csr_frame_count <= job.fcount;
               end
            end
         end
         start <= next_start;
         csr_valid <= next_csr;
      end
   end

   initial begin
      logic [FCOUNT_W-1:0] settings[10];
      shadow_fcount = FCOUNT_RESET;
      tlb_ptr = 0;
      victim = 0;
      acc_count = '0;
      flt_count = '0;
      hit_count = '0;
      for (int i = 0; i < TLB_N; i++) tlb_valid[i] = 1'b0;
      for (int i = 0; i < PAGE_ENTRIES; i++) page_valid[i] = 1'b0;
      for (int i = 0; i < FRAMES_N; i++) frame_used[i] = 1'b0;

      // Directed part: field extremes, hits, TLB wrap, eviction, lowered count.
      add_addr(16'h0000);
      add_addr(16'hFFFF);
      add_addr(16'h00FF);
      add_addr(16'hFF00);
      for (int i = 1; i <= 17; i++) add_addr({8'(i), 8'(i * 13)});
      add_addr(16'h0042);
      add_csr(9'd3);
      add_addr(16'h5A5A);
      add_csr(9'd1);
      add_addr(16'hA5A5);
      add_addr(16'h3C3C);
      add_addr(16'hA511);
      add_csr(9'd0);
      add_addr(16'h7777);
      add_addr(16'h8888);

      settings = '{9'd256, 9'd4, 9'd511, 9'd2, 9'd17, 9'd300, 9'd1, 9'd128, 9'd0, 9'd8};
      for (int p = 0; p < 10; p++) begin
         add_csr(settings[p]);
         for (int b = 0; b < 6; b++) add_random_block(30);
      end

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      while (pending_jobs.size() != 0 || start || csr_valid || expected_xlats.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_xlats.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
